/* rtl/bsi_pkg.sv */
`default_nettype none

package bsi_pkg;

	localparam int SAMPLE_RATE = 44100;
	localparam int MAX_SEG_LEN = 64;
	localparam int COS_DEPTH   = 256;

	localparam int SEG_W  = $clog2(MAX_SEG_LEN + 1);
	localparam int IDX_W  = $clog2(MAX_SEG_LEN);
	localparam int T_W    = $clog2(2 * COS_DEPTH);
	localparam int TIDX_W = $clog2(COS_DEPTH + 1);

	localparam int DIV_W     = 32;
	localparam int DIVISOR_W = 16;
	localparam int DIVCNT_W  = $clog2(DIV_W);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int LEVEL_FULL  = 999;
	localparam int UNIT_Q16    = 65536;
	localparam logic [27:0] RECIP_999 = 28'd137576530;
	localparam int RECIP_SHIFT = 37;
	localparam int SAT_HI      = 32767;
	localparam int SAT_LO      = -32768;

	localparam logic [1:0] MODE_TRUNC  = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_COSINE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_LEN = 2'd1;
	localparam logic [1:0] ST_CLAMPED  = 2'd2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b1;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DEN [1:7] = '{64'd2, 64'd12, 64'd30, 64'd56,
		64'd90, 64'd132, 64'd182};

	typedef enum logic [1:0] {JOB_ERR, JOB_TRUNC, JOB_SEG} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic        cosine;
		logic [9:0]  lev_a;
		logic [9:0]  lev_b;
		logic [31:0] count;
	} job_t;

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
	typedef enum logic [1:0] {B_IDLE, B_SETUP, B_RUN} back_state_t;

	typedef logic [COS_DEPTH:0][16:0] cos_tab_t;

	// quarter-wave cosine in Q1.16 from a truncated Taylor series in Q30
	function automatic logic [16:0] cos_entry(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] v;
		longint      sum;
		x    = HALF_PI_Q30 * 64'(k) / 64'(COS_DEPTH);
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		sum  = longint'(term);
		for (int j = 1; j <= 7; j++) begin
			term = term * x2 / TAYLOR_DEN[j];
			if ((j % 2) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		v = (64'(sum) + (64'd1 << 13)) >> 14;
		if (v > 64'(UNIT_Q16))
			v = 64'(UNIT_Q16);
		return v[16:0];
	endfunction

	function automatic cos_tab_t build_cos_tab();
		cos_tab_t tab;
		for (int k = 0; k <= COS_DEPTH; k++)
			tab[k] = cos_entry(k);
		return tab;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

`default_nettype wire

/* rtl/bsi_div.sv */
`default_nettype none

module bsi_div
	import bsi_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DIV_W-1:0]     dividend,
	input  wire logic [DIVISOR_W-1:0] divisor,
	output logic                      done,
	output logic [DIV_W-1:0]          quotient,
	output logic [DIVISOR_W-1:0]      remainder
);

	logic [DIV_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [DIVCNT_W-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVISOR_W:0]   shifted;
	logic                 ge;
	logic [DIVISOR_W-1:0] rem_next;

	always_comb begin
		shifted  = {rem_q, quo_q[DIV_W-1]};
		ge       = shifted >= {1'b0, div_q};
		rem_next = ge ? DIVISOR_W'(shifted - {1'b0, div_q}) : shifted[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIVCNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* rtl/bsi_fifo.sv */
`default_nettype none

module bsi_fifo
	import bsi_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_data,
	output logic      full,
	input  wire logic pop,
	output job_t      pop_data,
	output logic      empty
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full     = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

/* rtl/bsi_front.sv */
`default_nettype none

module bsi_front
	import bsi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] point_duration,
	input  wire logic [9:0]  point_level,
	input  wire logic [15:0] stride,
	input  wire logic [1:0]  mode,
	output logic             push,
	output job_t             push_job,
	input  wire logic        queue_full
);

	front_state_t state_q;
	front_state_t state_next;

	logic        failed_q;
	logic        have_prev_q;
	logic [9:0]  prev_level_q;
	logic [31:0] prev_length_q;
	logic [9:0]  lev_q;
	job_t        job_q;

	logic              accept;
	logic              div_start;
	logic              div_done;
	logic [DIV_W-1:0]  len;
	logic [DIVISOR_W-1:0] div_rem;
	logic [31:0]       scaled;
	logic              interp;
	logic              len_zero;

	assign scaled   = 32'(SAMPLE_RATE) * {16'd0, point_duration};
	assign interp   = (mode == MODE_LINEAR) || (mode == MODE_COSINE);
	assign len_zero = len == '0;

	bsi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (scaled),
		.divisor   (stride),
		.done      (div_done),
		.quotient  (len),
		.remainder (div_rem)
	);

	always_comb begin
		in_ready  = 1'b0;
		push      = 1'b0;
		accept    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready  = 1'b1;
				accept    = in_valid;
				div_start = in_valid && !failed_q && (stride != '0);
			end
			F_PUSH: begin
				push = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept)
					state_next = div_start ? F_DIV : F_PUSH;
			end
			F_DIV: begin
				if (div_done)
					state_next = (len_zero || !interp || have_prev_q) ? F_PUSH : F_IDLE;
			end
			F_PUSH: begin
				if (!queue_full)
					state_next = F_IDLE;
			end
			default: state_next = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= F_IDLE;
			failed_q      <= 1'b0;
			have_prev_q   <= 1'b0;
			prev_level_q  <= '0;
			prev_length_q <= '0;
		end else begin
			state_q <= state_next;
			if (accept && !failed_q && (stride == '0))
				failed_q <= 1'b1;
			if ((state_q == F_DIV) && div_done) begin
				if (len_zero) begin
					failed_q <= 1'b1;
				end else if (interp) begin
					have_prev_q   <= 1'b1;
					prev_level_q  <= lev_q;
					prev_length_q <= len;
				end else begin
					have_prev_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lev_q <= point_level;
			if (!div_start) begin
				job_q.kind   <= JOB_ERR;
				job_q.cosine <= 1'b0;
				job_q.lev_a  <= '0;
				job_q.lev_b  <= '0;
				job_q.count  <= '0;
			end
		end else if ((state_q == F_DIV) && div_done) begin
			job_q.cosine <= mode == MODE_COSINE;
			job_q.lev_a  <= prev_level_q;
			job_q.lev_b  <= lev_q;
			if (len_zero) begin
				job_q.kind  <= JOB_ERR;
				job_q.count <= '0;
			end else if (interp) begin
				job_q.kind  <= JOB_SEG;
				job_q.count <= prev_length_q;
			end else begin
				job_q.kind  <= JOB_TRUNC;
				job_q.count <= len;
			end
		end
	end

	assign push_job = job_q;

endmodule

`default_nettype wire

/* rtl/bsi_back.sv */
`default_nettype none

module bsi_back
	import bsi_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  job_t        job,
	input  wire logic   job_valid,
	output logic        job_pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [31:0] repeat_count,
	output logic [15:0] sample_value,
	output logic [1:0]  status_code,
	output logic        last_of_run
);

	typedef struct packed {
		logic        err;
		logic        bias;
		logic [31:0] rep_cnt;
		logic [1:0]  status;
		logic        last;
	} tag_t;

	back_state_t state_q;
	back_state_t state_next;

	logic adv;

	// segment sequencer
	logic [11:0]        base_q;
	logic signed [11:0] d_q;
	logic [SEG_W-1:0]   n_q;
	logic               clamp_q;
	logic               cos_q;
	logic signed [29:0] acc_q;
	logic [SEG_W-1:0]   rem_q;
	logic signed [29:0] dq_q;
	logic [SEG_W-1:0]   dr_q;
	logic [IDX_W-1:0]   i_q;

	logic               seg_last;
	logic [SEG_W:0]     rsum;
	logic               wrap;

	logic signed [11:0] d_new;
	logic [10:0]        absd;
	logic [11:0]        base_new;
	logic               clamp_new;
	logic [SEG_W-1:0]   n_new;

	logic                 div_start;
	logic                 div_done;
	logic [DIV_W-1:0]     div_dividend;
	logic [DIV_W-1:0]     div_quo;
	logic [DIVISOR_W-1:0] div_rem;
	logic signed [29:0]   q0;
	logic [SEG_W-1:0]     r0;

	logic               issue;
	tag_t               is_tag;
	logic               is_cos;
	logic [T_W-1:0]     is_t;
	logic signed [29:0] is_plin;
	logic [11:0]        is_base;

	logic               valid_s1;
	tag_t               tag_s1;
	logic               cos_s1;
	logic [T_W-1:0]     t_s1;
	logic signed [29:0] plin_s1;
	logic signed [11:0] d_s1;
	logic [11:0]        base_s1;

	logic               valid_s2;
	tag_t               tag_s2;
	logic signed [29:0] p_s2;
	logic [11:0]        base_s2;

	logic               valid_s3;
	tag_t               tag_s3;
	logic [26:0]        v_s3;

	logic               valid_s4;
	tag_t               tag_s4;
	logic [26:0]        v_s4;
	logic [17:0]        qe_s4;

	logic               valid_s5;
	tag_t               tag_s5;
	logic [17:0]        q_s5;

	logic               valid_s6;
	tag_t               tag_s6;
	logic [15:0]        sample_s6;

	logic [T_W-1:0]     mirror;
	logic [16:0]        tab_val;
	logic [17:0]        weight;
	logic signed [30:0] wprod;
	logic signed [29:0] p_next;
	logic signed [30:0] u_full;
	logic [54:0]        recip_prod;
	logic [27:0]        resid;
	logic [17:0]        q_next;
	logic signed [18:0] centred;
	logic [15:0]        sat_next;

	assign adv = !valid_s6 || out_ready;

	// job decode
	always_comb begin
		d_new     = $signed({1'b0, job.lev_b, 1'b0}) - $signed({1'b0, job.lev_a, 1'b0});
		absd      = d_new[11] ? 11'(-d_new) : d_new[10:0];
		base_new  = {1'b0, job.lev_a, 1'b0} + 12'(LEVEL_FULL);
		clamp_new = job.count > 32'(MAX_SEG_LEN);
		n_new     = clamp_new ? SEG_W'(MAX_SEG_LEN) : job.count[SEG_W-1:0];
		div_dividend = job.cosine ? DIV_W'(2 * COS_DEPTH) : {5'd0, absd, 16'd0};
	end

	bsi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (DIVISOR_W'(n_new)),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign q0 = $signed({1'b0, div_quo[28:0]});
	assign r0 = div_rem[SEG_W-1:0];

	assign seg_last = {1'b0, i_q} == (n_q - 1'b1);
	assign rsum     = {1'b0, rem_q} + {1'b0, dr_q};
	assign wrap     = rsum >= {1'b0, n_q};

	always_comb begin
		job_pop   = 1'b0;
		div_start = 1'b0;
		issue     = 1'b0;
		is_tag    = '0;
		is_cos    = 1'b0;
		is_t      = '0;
		is_plin   = '0;
		is_base   = '0;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					if (job.kind == JOB_SEG) begin
						job_pop   = 1'b1;
						div_start = 1'b1;
					end else if (adv) begin
						job_pop = 1'b1;
						issue   = 1'b1;
						is_tag.last = 1'b1;
						if (job.kind == JOB_TRUNC) begin
							is_tag.rep_cnt = job.count;
							is_tag.status  = ST_OK;
							is_base        = {2'b0, job.lev_b};
						end else begin
							is_tag.err    = 1'b1;
							is_tag.status = ST_ZERO_LEN;
						end
					end
				end
			end
			B_RUN: begin
				if (adv) begin
					issue          = 1'b1;
					is_tag.bias    = 1'b1;
					is_tag.rep_cnt = 32'd1;
					is_tag.status  = clamp_q ? ST_CLAMPED : ST_OK;
					is_tag.last    = seg_last;
					is_cos         = cos_q;
					is_t           = acc_q[T_W-1:0];
					is_plin        = acc_q;
					is_base        = base_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid && (job.kind == JOB_SEG))
					state_next = B_SETUP;
			end
			B_SETUP: begin
				if (div_done)
					state_next = B_RUN;
			end
			B_RUN: begin
				if (adv && seg_last)
					state_next = B_IDLE;
			end
			default: state_next = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_next;
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			base_q  <= base_new;
			d_q     <= d_new;
			n_q     <= n_new;
			clamp_q <= clamp_new;
			cos_q   <= job.cosine;
		end
		if ((state_q == B_SETUP) && div_done) begin
			acc_q <= '0;
			rem_q <= '0;
			i_q   <= '0;
			if (!cos_q && d_q[11] && (r0 != '0)) begin
				dq_q <= ~q0;
				dr_q <= n_q - r0;
			end else if (!cos_q && d_q[11]) begin
				dq_q <= -q0;
				dr_q <= '0;
			end else begin
				dq_q <= q0;
				dr_q <= r0;
			end
		end else if ((state_q == B_RUN) && adv) begin
			acc_q <= acc_q + dq_q + 30'(wrap);
			rem_q <= wrap ? SEG_W'(rsum - {1'b0, n_q}) : rsum[SEG_W-1:0];
			i_q   <= i_q + 1'b1;
		end
	end

	// weight from the quarter-wave table, mirrored for the second quarter
	always_comb begin
		mirror  = T_W'(2 * COS_DEPTH) - t_s1;
		tab_val = (t_s1 <= T_W'(COS_DEPTH)) ? COS_TAB[TIDX_W'(t_s1)] : COS_TAB[TIDX_W'(mirror)];
		weight  = (t_s1 <= T_W'(COS_DEPTH)) ? 18'(UNIT_Q16) - {1'b0, tab_val}
			: 18'(UNIT_Q16) + {1'b0, tab_val};
		wprod   = d_s1 * $signed({1'b0, weight});
		p_next  = cos_s1 ? 30'(wprod >>> 1) : plin_s1;
	end

	// biased numerator, halved, divided by 999 via reciprocal, then centred and saturated
	always_comb begin
		u_full     = $signed({3'b0, base_s2, 16'd0}) + 31'sd999 + 31'(p_s2);
		recip_prod = 55'(v_s3) * 55'(RECIP_999);
		resid      = 28'(v_s4) - 28'(qe_s4) * 28'(LEVEL_FULL);
		q_next     = (resid >= 28'(LEVEL_FULL)) ? qe_s4 + 1'b1 : qe_s4;
		centred    = $signed({1'b0, q_s5}) - (tag_s5.bias ? 19'sd65536 : 19'sd0);
		if (tag_s5.err)
			sat_next = '0;
		else if (centred > 19'(SAT_HI))
			sat_next = 16'(SAT_HI);
		else if (centred < 19'(SAT_LO))
			sat_next = 16'(SAT_LO);
		else
			sat_next = centred[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1    <= is_tag;
			cos_s1    <= is_cos;
			t_s1      <= is_t;
			plin_s1   <= is_plin;
			d_s1      <= d_q;
			base_s1   <= is_base;

			tag_s2    <= tag_s1;
			p_s2      <= p_next;
			base_s2   <= base_s1;

			tag_s3    <= tag_s2;
			v_s3      <= u_full[27:1];

			tag_s4    <= tag_s3;
			v_s4      <= v_s3;
			qe_s4     <= recip_prod[RECIP_SHIFT +: 18];

			tag_s5    <= tag_s4;
			q_s5      <= q_next;

			tag_s6    <= tag_s5;
			sample_s6 <= sat_next;
		end
	end

	assign out_valid    = valid_s6;
	assign repeat_count = tag_s6.rep_cnt;
	assign sample_value = sample_s6;
	assign status_code  = tag_s6.status;
	assign last_of_run  = tag_s6.last;

endmodule

`default_nettype wire

/* rtl/breakpoint_sample_interpolator.sv */
// Channel  Dir  Handshake        Payload (lowest bit up)
// s_*      in   tvalid/tready    tdata: point_duration[15:0], point_level[25:16]
// m_*      out  tvalid/tready    tdata: repeat_count[31:0], sample_value[47:32];
//                                tuser: status_code; tlast: last_of_run
// cfg_*    in   cfg_we           cfg_index 0 stride_divisor, 1 interp_mode; cfg_wdata
//
// Front: accepts a breakpoint, runs its 32-step length divider and hands the job to a
// two-entry queue; a breakpoint only held pushes no job; once failed, no divide runs.
// Back: an error or hold result leaves the queue with no setup; a segment of n samples
// (n <= 64) first runs a second 32-step divider, then issues its n samples and returns
// to idle. Results leave a six-stage pipeline; m_tready low stalls it as a whole while
// a result waits. Reset clears the failure flag and held breakpoint, stride to 1.
`default_nettype none

module breakpoint_sample_interpolator
	import bsi_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [31:0]          s_tdata,   // point_duration, point_level
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [47:0]               m_tdata,   // repeat_count, sample_value
	output logic [1:0]                m_tuser,   // status_code
	output logic                      m_tlast,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_wdata
);

	logic [15:0] stride_q;
	logic [1:0]  mode_q;

	logic        push;
	job_t        push_job;
	logic        queue_full;
	job_t        head_job;
	logic        queue_empty;
	logic        job_pop;
	logic [31:0] repeat_count;
	logic [15:0] sample_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= 16'd1;
			mode_q   <= MODE_TRUNC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRIDE: stride_q <= cfg_wdata;
				REG_MODE:   mode_q   <= cfg_wdata[1:0];
				default: begin
				end
			endcase
		end
	end

	bsi_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.point_duration (s_tdata[15:0]),
		.point_level    (s_tdata[25:16]),
		.stride         (stride_q),
		.mode           (mode_q),
		.push           (push),
		.push_job       (push_job),
		.queue_full     (queue_full)
	);

	bsi_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (queue_full),
		.pop       (job_pop),
		.pop_data  (head_job),
		.empty     (queue_empty)
	);

	bsi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (head_job),
		.job_valid    (!queue_empty),
		.job_pop      (job_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.repeat_count (repeat_count),
		.sample_value (sample_value),
		.status_code  (m_tuser),
		.last_of_run  (m_tlast)
	);

	assign m_tdata = {sample_value, repeat_count};

endmodule

`default_nettype wire
